>>> design/vn3d_pkg.sv
`default_nettype none
package vn3d_pkg;

	// Stage counts of the back pipeline and the queue depth
	localparam int unsigned SqrtSteps = 16;
	localparam int unsigned DivSteps  = 15;
	localparam int unsigned QueueDepth = 4;

	// One classified vector as it waits in the queue
	typedef struct packed {
		logic [31:0] sum;
		logic [15:0] ax;
		logic [15:0] ay;
		logic [15:0] az;
		logic        sx;
		logic        sy;
		logic        sz;
	} vn3d_item_t;

	// Partial remainder and root of the square-root recurrence
	typedef struct packed {
		logic [19:0] rem;
		logic [15:0] root;
	} vn3d_sq_t;

	// Queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} vn3d_qstat_t;

	// One digit of the restoring square root: bring down two bits
	function automatic vn3d_sq_t sqrt_step(input vn3d_sq_t cur, input logic [1:0] pair);
		logic [19:0] r2;
		logic [19:0] trial;
		vn3d_sq_t    nxt;
		r2    = {cur.rem[17:0], pair};
		trial = {2'b00, cur.root, 2'b01};
		if (r2 >= trial) begin
			nxt.rem  = r2 - trial;
			nxt.root = {cur.root[14:0], 1'b1};
		end else begin
			nxt.rem  = r2;
			nxt.root = {cur.root[14:0], 1'b0};
		end
		return nxt;
	endfunction

	// One quotient bit of restoring division; returns {bit, remainder}
	function automatic logic [16:0] div_step(input logic [15:0] rem, input logic bit_in,
			input logic [15:0] dvs);
		logic [16:0] r2;
		logic [16:0] res;
		r2 = {rem, bit_in};
		if (r2 >= {1'b0, dvs}) begin
			res = {1'b1, 16'(r2 - {1'b0, dvs})};
		end else begin
			res = {1'b0, r2[15:0]};
		end
		return res;
	endfunction

endpackage
`default_nettype wire

>>> design/vn3d_front.sv
`default_nettype none
module vn3d_front import vn3d_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [47:0] in_data,
	input  wire vn3d_qstat_t qstat,
	output logic             push,
	output vn3d_item_t       push_item
);

	logic [15:0] cx, cy, cz, ax, ay, az;
	logic        vld_s1;
	logic [31:0] sqx_s1, sqy_s1, sqz_s1;
	logic [15:0] ax_s1, ay_s1, az_s1;
	logic        sx_s1, sy_s1, sz_s1;

	// Take magnitudes of the components
	assign cx = in_data[15:0];
	assign cy = in_data[31:16];
	assign cz = in_data[47:32];
	assign ax = cx[15] ? 16'(-cx) : cx;
	assign ay = cy[15] ? 16'(-cy) : cy;
	assign az = cz[15] ? 16'(-cz) : cz;

	assign push     = vld_s1 && !qstat.full;
	assign in_ready = !vld_s1 || !qstat.full;

	// Square each component
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sqx_s1 <= ax * ax;
			sqy_s1 <= ay * ay;
			sqz_s1 <= az * az;
			ax_s1  <= ax;
			ay_s1  <= ay;
			az_s1  <= az;
			sx_s1  <= cx[15];
			sy_s1  <= cy[15];
			sz_s1  <= cz[15];
		end
	end

	// Sum the squares into the queue entry
	always_comb begin
		push_item.sum = sqx_s1 + sqy_s1 + sqz_s1;
		push_item.ax  = ax_s1;
		push_item.ay  = ay_s1;
		push_item.az  = az_s1;
		push_item.sx  = sx_s1;
		push_item.sy  = sy_s1;
		push_item.sz  = sz_s1;
	end

endmodule
`default_nettype wire

>>> design/vn3d_queue.sv
`default_nettype none
module vn3d_queue import vn3d_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire vn3d_item_t  push_item,
	input  wire logic        pop,
	output vn3d_item_t       head,
	output vn3d_qstat_t      qstat
);

	localparam int unsigned Aw = $clog2(QueueDepth);

	vn3d_item_t          mem_q [QueueDepth];
	logic [Aw-1:0]       wr_q, rd_q;
	logic [Aw:0]         cnt_q;

	assign qstat.full  = (cnt_q == (Aw+1)'(QueueDepth));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rd_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule
`default_nettype wire

>>> design/vn3d_back.sv
`default_nettype none
module vn3d_back import vn3d_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire vn3d_item_t  head,
	input  wire vn3d_qstat_t qstat,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [95:0]      out_data,
	output logic             out_zero
);

	logic adv;

	// Square-root stages
	logic       sq_vld_q  [SqrtSteps+1];
	vn3d_item_t sq_item_q [SqrtSteps+1];
	vn3d_sq_t   sq_st_q   [SqrtSteps+1];

	// Division stages, three lanes
	logic        dv_vld_q  [DivSteps+1];
	vn3d_item_t  dv_item_q [DivSteps+1];
	logic [15:0] dv_mag_q  [DivSteps+1];
	logic [15:0] dv_rx_q   [DivSteps+1];
	logic [15:0] dv_ry_q   [DivSteps+1];
	logic [15:0] dv_rz_q   [DivSteps+1];
	logic [14:0] dv_qx_q   [DivSteps+1];
	logic [14:0] dv_qy_q   [DivSteps+1];
	logic [14:0] dv_qz_q   [DivSteps+1];

	logic        zero_f;
	logic [15:0] ux, uy, uz;

	assign adv = !out_valid || out_ready;
	assign pop = adv && !qstat.empty;

	// Advance valid bits through the whole pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= SqrtSteps; j++) sq_vld_q[j] <= 1'b0;
			for (int j = 0; j <= DivSteps; j++) dv_vld_q[j] <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			sq_vld_q[0] <= !qstat.empty;
			for (int j = 0; j < SqrtSteps; j++) sq_vld_q[j+1] <= sq_vld_q[j];
			dv_vld_q[0] <= sq_vld_q[SqrtSteps];
			for (int j = 0; j < DivSteps; j++) dv_vld_q[j+1] <= dv_vld_q[j];
			out_valid <= dv_vld_q[DivSteps];
		end
	end

	// Square root: two sum bits per stage
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_item_q[0] <= head;
			sq_st_q[0]   <= '0;
			for (int j = 0; j < SqrtSteps; j++) begin
				sq_item_q[j+1] <= sq_item_q[j];
				sq_st_q[j+1]   <= sqrt_step(sq_st_q[j], sq_item_q[j].sum[31-2*j -: 2]);
			end
		end
	end

	// Division: one quotient bit per lane per stage
	always_ff @(posedge clk) begin
		logic [16:0] rx, ry, rz;
		if (adv) begin
			dv_item_q[0] <= sq_item_q[SqrtSteps];
			dv_mag_q[0]  <= sq_st_q[SqrtSteps].root;
			dv_rx_q[0]   <= {1'b0, sq_item_q[SqrtSteps].ax[15:1]};
			dv_ry_q[0]   <= {1'b0, sq_item_q[SqrtSteps].ay[15:1]};
			dv_rz_q[0]   <= {1'b0, sq_item_q[SqrtSteps].az[15:1]};
			dv_qx_q[0]   <= '0;
			dv_qy_q[0]   <= '0;
			dv_qz_q[0]   <= '0;
			for (int j = 0; j < DivSteps; j++) begin
				rx = div_step(dv_rx_q[j], (j == 0) && dv_item_q[j].ax[0], dv_mag_q[j]);
				ry = div_step(dv_ry_q[j], (j == 0) && dv_item_q[j].ay[0], dv_mag_q[j]);
				rz = div_step(dv_rz_q[j], (j == 0) && dv_item_q[j].az[0], dv_mag_q[j]);
				dv_item_q[j+1] <= dv_item_q[j];
				dv_mag_q[j+1]  <= dv_mag_q[j];
				dv_rx_q[j+1]   <= rx[15:0];
				dv_ry_q[j+1]   <= ry[15:0];
				dv_rz_q[j+1]   <= rz[15:0];
				dv_qx_q[j+1]   <= {dv_qx_q[j][13:0], rx[16]};
				dv_qy_q[j+1]   <= {dv_qy_q[j][13:0], ry[16]};
				dv_qz_q[j+1]   <= {dv_qz_q[j][13:0], rz[16]};
			end
		end
	end

	// Apply signs and force zero for a zero vector
	always_comb begin
		zero_f = (dv_mag_q[DivSteps] == '0);
		ux = dv_item_q[DivSteps].sx ? 16'(-{1'b0, dv_qx_q[DivSteps]}) : {1'b0, dv_qx_q[DivSteps]};
		uy = dv_item_q[DivSteps].sy ? 16'(-{1'b0, dv_qy_q[DivSteps]}) : {1'b0, dv_qy_q[DivSteps]};
		uz = dv_item_q[DivSteps].sz ? 16'(-{1'b0, dv_qz_q[DivSteps]}) : {1'b0, dv_qz_q[DivSteps]};
		if (zero_f) begin
			ux = '0;
			uy = '0;
			uz = '0;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= {uz, uy, ux, dv_mag_q[DivSteps], dv_item_q[DivSteps].sum};
			out_zero <= zero_f;
		end
	end

endmodule
`default_nettype wire

>>> design/vector_normalize_3d.sv
// Channel   Dir  Handshake          Contents
// s_axis    in   s_tvalid/s_tready  comp_x, comp_y, comp_z
// m_axis    out  m_tvalid/m_tready  sum_squares, magnitude, unit_x/y/z; zero_vector
//
// One vector per cycle when the output is taken every cycle.
// A result passes one front register, one queue entry, 17 square-root and
// 16 divide registers and the output register; the digit recurrences set
// the depth.
// Reset clears valid bits and queue pointers; no clearing pass.
// A stalled output freezes the back pipeline; the front fills the queue of 4.
`default_nettype none
module vector_normalize_3d import vn3d_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // comp_x [15:0], comp_y [31:16], comp_z [47:32]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata,  // sum_squares, magnitude, unit_x, unit_y, unit_z
	output logic             m_tuser   // zero_vector
);

	logic        push, pop;
	vn3d_item_t  push_item, head;
	vn3d_qstat_t qstat;

	vn3d_front u_front (
		.clk, .arst_n,
		.in_valid (s_tvalid), .in_ready (s_tready), .in_data (s_tdata),
		.qstat, .push, .push_item
	);

	vn3d_queue u_queue (
		.clk, .arst_n, .push, .push_item, .pop, .head, .qstat
	);

	vn3d_back u_back (
		.clk, .arst_n, .head, .qstat, .pop,
		.out_valid (m_tvalid), .out_ready (m_tready),
		.out_data (m_tdata), .out_zero (m_tuser)
	);

	// Zero flag matches a zero magnitude and zero unit outputs
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == (m_tdata[47:32] == 16'd0)) &&
			(!m_tuser || m_tdata[95:48] == 48'd0))
		else $error("zero flag disagrees with result");

	// Magnitude squared does not exceed the sum
	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({16'd0, m_tdata[47:32]} * {16'd0, m_tdata[47:32]} <= m_tdata[31:0]))
		else $error("magnitude too large");

	// Input stalls only when the queue is full
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> qstat.full)
		else $error("front stalled with queue space");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] sum_sq;
		logic [15:0] mag;
		logic [15:0] ux;
		logic [15:0] uy;
		logic [15:0] uz;
		logic        zero;
	} norm_res_t;

	typedef struct {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		bit          typed;
		norm_res_t   res;
	} vec_row_t;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned DrainCycles = 60;
	localparam int unsigned RandomVectors = 450;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic        m_tuser;

	norm_res_t   expected_q[$];
	vec_row_t    vec_table[$];
	int unsigned fail_count;
	int unsigned cycle_count;
	bit          calm_phase;

	vector_normalize_3d dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Integer floor square root by bit pairs
	function automatic logic [15:0] floor_sqrt(input logic [31:0] n);
		logic [31:0] rest;
		logic [31:0] root;
		logic [31:0] probe;
		rest  = n;
		root  = 0;
		probe = 32'h4000_0000;
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest = rest - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root[15:0];
	endfunction

	// Component scaled to Q1.14 by the magnitude, truncated toward zero
	function automatic logic [15:0] unit_of(input logic signed [15:0] c, input logic [15:0] m);
		logic [31:0] a;
		logic [31:0] q;
		if (m == 0)
			return 16'd0;
		a = c[15] ? 32'(-32'(c)) : 32'(c);
		q = (a << 14) / 32'(m);
		if (c[15])
			q = -q;
		return q[15:0];
	endfunction

	function automatic norm_res_t normalise(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z);
		norm_res_t r;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sz;
		sx       = 32'(signed'(x));
		sy       = 32'(signed'(y));
		sz       = 32'(signed'(z));
		r.sum_sq = 32'(sx * sx) + 32'(sy * sy) + 32'(sz * sz);
		r.mag    = floor_sqrt(r.sum_sq);
		r.ux     = unit_of(x, r.mag);
		r.uy     = unit_of(y, r.mag);
		r.uz     = unit_of(z, r.mag);
		r.zero   = (r.mag == 0);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		fail_count++;
	endtask

	function automatic bit idle_now();
		return !calm_phase && ($urandom_range(99) < 19);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Count cycles and stop a stuck run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Compare each result item with the oldest expectation
	always @(posedge clk) begin
		norm_res_t got;
		norm_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[47:32], m_tdata[63:48], m_tdata[79:64],
				m_tdata[95:80], m_tuser};
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected item", got.sum_sq, 0);
			end else begin
				want = expected_q.pop_front();
				if (got.sum_sq !== want.sum_sq)
					report_mismatch("sum_squares", got.sum_sq, want.sum_sq);
				if (got.mag !== want.mag)
					report_mismatch("magnitude", 32'(got.mag), 32'(want.mag));
				if (got.ux !== want.ux)
					report_mismatch("unit_x", 32'(got.ux), 32'(want.ux));
				if (got.uy !== want.uy)
					report_mismatch("unit_y", 32'(got.uy), 32'(want.uy));
				if (got.uz !== want.uz)
					report_mismatch("unit_z", 32'(got.uz), 32'(want.uz));
				if (got.zero !== want.zero)
					report_mismatch("zero_vector", 32'(got.zero), 32'(want.zero));
			end
		end
	end

	// Stall the output at random
	always @(negedge clk) begin
		m_tready <= arst_n && !idle_now();
	end

	// Log each accepted input item with its expected result
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			expected_q.push_back(normalise(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]));
	end

	task automatic add_row(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
			input bit typed, input norm_res_t res);
		vec_row_t r;
		r.x     = x;
		r.y     = y;
		r.z     = z;
		r.typed = typed;
		r.res   = res;
		vec_table.push_back(r);
	endtask

	task automatic send_vector(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		while (idle_now()) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {z, y, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] random_comp();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'(signed'($urandom_range(8)) - 4);
			3: return 16'd0;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		norm_res_t none;
		int unsigned drain;
		none        = '0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		fail_count  = 0;
		cycle_count = 0;
		calm_phase  = 1'b0;

		// Directed rows: zero vector, extremes, axis vectors, mixed signs
		add_row(16'h0000, 16'h0000, 16'h0000, 1, {32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1});
		add_row(16'h0100, 16'h0000, 16'h0000, 1,
			{32'h0001_0000, 16'h0100, 16'h4000, 16'd0, 16'd0, 1'b0});
		add_row(16'h0000, 16'hFF00, 16'h0000, 1,
			{32'h0001_0000, 16'h0100, 16'd0, 16'hC000, 16'd0, 1'b0});
		add_row(16'h0000, 16'h0000, 16'h8000, 1,
			{32'h4000_0000, 16'h8000, 16'd0, 16'd0, 16'hC000, 1'b0});
		add_row(16'h8000, 16'h8000, 16'h8000, 1,
			{32'hC000_0000, 16'd56755, 16'hDB0D, 16'hDB0D, 16'hDB0D, 1'b0});
		add_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 0, none);
		add_row(16'h0001, 16'h0000, 16'h0000, 0, none);
		add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, none);
		add_row(16'h7FFF, 16'h8000, 16'h0001, 0, none);
		add_row(16'h0300, 16'h0400, 16'h0000, 0, none);
		add_row(16'hAAAA, 16'h5555, 16'hAAAA, 0, none);
		add_row(16'h5555, 16'hAAAA, 16'h5555, 0, none);
		add_row(16'h0001, 16'h0001, 16'h0001, 0, none);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the table; typed rows also check the predictor itself
		foreach (vec_table[i]) begin
			if (vec_table[i].typed &&
					normalise(vec_table[i].x, vec_table[i].y, vec_table[i].z) !== vec_table[i].res)
				report_mismatch("table row", i, 0);
			send_vector(vec_table[i].x, vec_table[i].y, vec_table[i].z);
		end

		// Random vectors, the middle stretch without idling
		for (int unsigned n = 0; n < RandomVectors; n++) begin
			calm_phase = (n >= 150 && n < 250);
			send_vector(random_comp(), random_comp(), random_comp());
		end
		calm_phase = 1'b0;
		s_tvalid <= 1'b0;

		// Drain the pipeline, then watch for stray items
		while (expected_q.size() != 0) @(posedge clk);
		for (drain = 0; drain < DrainCycles; drain++) @(posedge clk);

		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
